FILE: hdl/krsd_pkg.sv
// Shared types and constants for the keypad row scan and debounce unit.
`default_nettype none
package krsd_pkg;

   localparam int unsigned ROW_WIDTH  = 2;
   localparam int unsigned LINE_WIDTH = 4;
   localparam int unsigned CODE_WIDTH = 5;
   localparam int unsigned CONFIRM_WIDTH = 8;
   localparam int unsigned COUNT_WIDTH   = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CODE_WIDTH-1:0] NO_KEY_CODE = 5'd16;
   localparam logic [LINE_WIDTH-1:0] ALL_LINES_HIGH = 4'hF;

   localparam logic [CONFIRM_WIDTH-1:0] CONFIRM_READS_RESET = 8'd5;
   localparam logic [COUNT_WIDTH-1:0]   QUIET_READS_RESET   = 16'd2500;
   localparam logic [COUNT_WIDTH-1:0]   HOLD_LIMIT_RESET    = 16'd11250;
   localparam logic [COUNT_WIDTH-1:0]   COUNT_MAX           = 16'hFFFF;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CONFIRM_READS = 2'd0,
      CSR_QUIET_READS   = 2'd1,
      CSR_HOLD_LIMIT    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_CONFIRM = 2'd1,
      PHASE_RELEASE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CONFIRM_WIDTH-1:0] confirm_reads;
      logic [COUNT_WIDTH-1:0]   quiet_reads;
      logic [COUNT_WIDTH-1:0]   hold_limit;
   } cfg_type;

   typedef struct packed {
      logic [LINE_WIDTH-1:0] row_drive;
      logic                  done_res;
      logic [ROW_WIDTH-1:0]  checked_row;
      logic [CODE_WIDTH-1:0] key_code;
      logic                  busy_res;
   } result_type;

endpackage
`default_nettype wire

FILE: hdl/krsd_scan_fsm.sv
// Scan state machine: row drive, press confirm and release wait counters.
`default_nettype none
module krsd_scan_fsm (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  step,
   input  wire logic                                  start_req,
   input  wire logic [krsd_pkg::ROW_WIDTH-1:0]        row_select,
   input  wire logic [krsd_pkg::LINE_WIDTH-1:0]       column_sample,
   input  wire krsd_pkg::cfg_type                     cfg,
   output krsd_pkg::result_type                       result
);

   krsd_pkg::phase_type                     phase_ff, phase_in;
   logic [krsd_pkg::LINE_WIDTH-1:0]         captured_ff, captured_in;
   logic [krsd_pkg::ROW_WIDTH-1:0]          row_ff, row_in;
   logic [krsd_pkg::LINE_WIDTH-1:0]         drive_ff, drive_in;
   logic [krsd_pkg::CONFIRM_WIDTH-1:0]      confirm_ff, confirm_in;
   logic [krsd_pkg::COUNT_WIDTH-1:0]        quiet_ff, quiet_in;
   logic [krsd_pkg::COUNT_WIDTH-1:0]        hold_ff, hold_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= krsd_pkg::PHASE_IDLE;
         captured_ff <= '0;
         row_ff      <= '0;
         drive_ff    <= krsd_pkg::ALL_LINES_HIGH;
         confirm_ff  <= '0;
         quiet_ff    <= '0;
         hold_ff     <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         captured_ff <= captured_in;
         row_ff      <= row_in;
         drive_ff    <= drive_in;
         confirm_ff  <= confirm_in;
         quiet_ff    <= quiet_in;
         hold_ff     <= hold_in;
      end
   end

   always_comb begin
      logic                              done;
      logic [krsd_pkg::CODE_WIDTH-1:0]   code;
      logic [krsd_pkg::CONFIRM_WIDTH-1:0] confirm_next;
      logic                              no_cols;
      logic                              multi_cols;

      phase_in    = phase_ff;
      captured_in = captured_ff;
      row_in      = row_ff;
      drive_in    = drive_ff;
      confirm_in  = confirm_ff;
      quiet_in    = quiet_ff;
      hold_in     = hold_ff;
      done        = 1'b0;
      code        = '0;
      no_cols     = (column_sample == '0);
      multi_cols  = ((column_sample & (column_sample - 1'b1)) != '0);
      confirm_next = confirm_ff + 1'b1;

      unique case (phase_ff)
         krsd_pkg::PHASE_CONFIRM: begin
            if (no_cols) begin
               done = 1'b1;
               code = krsd_pkg::NO_KEY_CODE;
            end else begin
               confirm_in = confirm_next;
               if (confirm_next >= cfg.confirm_reads || confirm_next == '0) begin
                  phase_in = krsd_pkg::PHASE_RELEASE;
                  quiet_in = '0;
                  hold_in  = '0;
               end
            end
         end
         krsd_pkg::PHASE_RELEASE: begin
            if (!no_cols) begin
               quiet_in = '0;
            end else if (quiet_ff != krsd_pkg::COUNT_MAX) begin
               quiet_in = quiet_ff + 1'b1;
            end
            if (hold_ff != krsd_pkg::COUNT_MAX) begin
               hold_in = hold_ff + 1'b1;
            end
            if (quiet_in >= cfg.quiet_reads || hold_in >= cfg.hold_limit) begin
               done = 1'b1;
               code = {1'b0, captured_ff};
            end
         end
         default: begin
            phase_in = krsd_pkg::PHASE_IDLE;
            if (start_req) begin
               row_in      = row_select;
               drive_in    = krsd_pkg::ALL_LINES_HIGH &
                             ~(krsd_pkg::LINE_WIDTH'(1) << row_select);
               captured_in = column_sample;
               if (no_cols) begin
                  done = 1'b1;
                  code = krsd_pkg::NO_KEY_CODE;
               end else if (multi_cols) begin
                  done = 1'b1;
                  code = {1'b0, column_sample};
               end else begin
                  phase_in   = krsd_pkg::PHASE_CONFIRM;
                  confirm_in = '0;
               end
            end
         end
      endcase

      if (done) begin
         phase_in = krsd_pkg::PHASE_IDLE;
      end

      result.row_drive   = drive_in;
      result.done_res    = done;
      result.checked_row = done ? row_in : '0;
      result.key_code    = code;
      result.busy_res    = (phase_in != krsd_pkg::PHASE_IDLE);
   end

endmodule
`default_nettype wire

FILE: hdl/keypad_row_scan_debounce_unit.sv
// Top level of the keypad row scan and debounce unit.
// Each request is one sample tick of the four column lines together with a
// start flag and a row select. Every accepted request yields exactly one
// response: the row line pattern, a done flag with the checked row and key
// code (16 means no key), and a busy flag.
// The response is registered at the edge that accepts the request. Throughput
// is one request per cycle when the receiver does not stall, set by the single
// state update of the scan state machine per sample.
// The response register is taken over as it drains: req_ready is high when
// the response register is empty or rsp_ready is high, so a stalled receiver
// holds off new requests and the state machine does not advance.
// The csr port writes confirm_reads (0), quiet_reads (1) and hold_limit (2);
// other indexes are ignored.
// Reset (synchronous) returns the scan to idle, row lines all high, empties
// the response register and restores register defaults 5, 2500 and 11250.
`default_nettype none
module keypad_row_scan_debounce_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_start_req,
   input  wire logic [krsd_pkg::ROW_WIDTH-1:0]         req_row_select,
   input  wire logic [krsd_pkg::LINE_WIDTH-1:0]        req_column_sample,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [krsd_pkg::LINE_WIDTH-1:0]             rsp_row_drive,
   output logic                                        rsp_done_res,
   output logic [krsd_pkg::ROW_WIDTH-1:0]              rsp_checked_row,
   output logic [krsd_pkg::CODE_WIDTH-1:0]             rsp_key_code,
   output logic                                        rsp_busy_res,
   input  wire logic                                   csr_write_enable,
   input  wire logic [krsd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [krsd_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   krsd_pkg::cfg_type    cfg_ff;
   krsd_pkg::result_type step_result;
   krsd_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.confirm_reads <= krsd_pkg::CONFIRM_READS_RESET;
         cfg_ff.quiet_reads   <= krsd_pkg::QUIET_READS_RESET;
         cfg_ff.hold_limit    <= krsd_pkg::HOLD_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            krsd_pkg::CSR_CONFIRM_READS:
               cfg_ff.confirm_reads <= csr_write_data[krsd_pkg::CONFIRM_WIDTH-1:0];
            krsd_pkg::CSR_QUIET_READS:
               cfg_ff.quiet_reads <= csr_write_data[krsd_pkg::COUNT_WIDTH-1:0];
            krsd_pkg::CSR_HOLD_LIMIT:
               cfg_ff.hold_limit <= csr_write_data[krsd_pkg::COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   krsd_scan_fsm u_scan_fsm (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .start_req     (req_start_req),
      .row_select    (req_row_select),
      .column_sample (req_column_sample),
      .cfg           (cfg_ff),
      .result        (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_drive   = rsp_ff.row_drive;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_checked_row = rsp_ff.checked_row;
   assign rsp_key_code    = rsp_ff.key_code;
   assign rsp_busy_res    = rsp_ff.busy_res;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the keypad row scan and debounce unit: directed and random sample streams.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import krsd_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_start_req = 1'b0;
   logic [ROW_WIDTH-1:0]        req_row_select = '0;
   logic [LINE_WIDTH-1:0]       req_column_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [LINE_WIDTH-1:0]       rsp_row_drive;
   logic                        rsp_done_res;
   logic [ROW_WIDTH-1:0]        rsp_checked_row;
   logic [CODE_WIDTH-1:0]       rsp_key_code;
   logic                        rsp_busy_res;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_write_data = '0;

   keypad_row_scan_debounce_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_start_req     (req_start_req),
      .req_row_select    (req_row_select),
      .req_column_sample (req_column_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_row_drive     (rsp_row_drive),
      .rsp_done_res      (rsp_done_res),
      .rsp_checked_row   (rsp_checked_row),
      .rsp_key_code      (rsp_key_code),
      .rsp_busy_res      (rsp_busy_res),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #2 clock = ~clock;

   // scan state mirror
   cfg_type                  scan_cfg;
   phase_type                scan_phase;
   logic [LINE_WIDTH-1:0]    held_code;
   logic [ROW_WIDTH-1:0]     scan_row;
   logic [LINE_WIDTH-1:0]    scan_lines;
   logic [CONFIRM_WIDTH-1:0] confirm_cnt;
   logic [COUNT_WIDTH-1:0]   quiet_cnt;
   logic [COUNT_WIDTH-1:0]   hold_cnt;

   result_type pending_scan_results[$];
   int mismatch_count = 0;
   int requests_sent = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   function automatic void reset_scan_state();
      scan_cfg.confirm_reads = CONFIRM_READS_RESET;
      scan_cfg.quiet_reads   = QUIET_READS_RESET;
      scan_cfg.hold_limit    = HOLD_LIMIT_RESET;
      scan_phase  = PHASE_IDLE;
      held_code   = '0;
      scan_row    = '0;
      scan_lines  = ALL_LINES_HIGH;
      confirm_cnt = '0;
      quiet_cnt   = '0;
      hold_cnt    = '0;
   endfunction

   function automatic void store_setting(logic [CSR_INDEX_WIDTH-1:0] idx,
                                         logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_CONFIRM_READS: scan_cfg.confirm_reads = data[CONFIRM_WIDTH-1:0];
         CSR_QUIET_READS:   scan_cfg.quiet_reads   = data;
         CSR_HOLD_LIMIT:    scan_cfg.hold_limit    = data;
         default: ;
      endcase
   endfunction

   function automatic result_type next_scan_result(logic start, logic [ROW_WIDTH-1:0] row,
                                                   logic [LINE_WIDTH-1:0] cols);
      result_type res;
      logic done;
      logic [CODE_WIDTH-1:0] code;
      done = 1'b0;
      code = '0;
      case (scan_phase)
         PHASE_CONFIRM: begin
            if (cols == '0) begin
               done = 1'b1;
               code = NO_KEY_CODE;
            end else begin
               confirm_cnt = confirm_cnt + 1'b1;
               if (confirm_cnt >= scan_cfg.confirm_reads || confirm_cnt == '0) begin
                  scan_phase = PHASE_RELEASE;
                  quiet_cnt  = '0;
                  hold_cnt   = '0;
               end
            end
         end
         PHASE_RELEASE: begin
            if (cols != '0)
               quiet_cnt = '0;
            else if (quiet_cnt < COUNT_MAX)
               quiet_cnt = quiet_cnt + 1'b1;
            if (hold_cnt < COUNT_MAX)
               hold_cnt = hold_cnt + 1'b1;
            if (quiet_cnt >= scan_cfg.quiet_reads || hold_cnt >= scan_cfg.hold_limit) begin
               done = 1'b1;
               code = {1'b0, held_code};
            end
         end
         default: begin
            scan_phase = PHASE_IDLE;
            if (start) begin
               scan_row   = row;
               scan_lines = ALL_LINES_HIGH & ~(4'b0001 << row);
               held_code  = cols;
               if (cols == '0) begin
                  done = 1'b1;
                  code = NO_KEY_CODE;
               end else if ((cols & (cols - 4'd1)) != 4'd0) begin
                  done = 1'b1;
                  code = {1'b0, cols};
               end else begin
                  scan_phase  = PHASE_CONFIRM;
                  confirm_cnt = '0;
               end
            end
         end
      endcase
      if (done)
         scan_phase = PHASE_IDLE;
      res.row_drive   = scan_lines;
      res.done_res    = done;
      res.checked_row = done ? scan_row : '0;
      res.key_code    = done ? code : '0;
      res.busy_res    = (scan_phase != PHASE_IDLE);
      return res;
   endfunction

   function automatic logic [LINE_WIDTH-1:0] one_hot_column();
      return 4'b0001 << $urandom_range(3);
   endfunction

   function automatic logic [LINE_WIDTH-1:0] pressed_columns();
      return 4'($urandom_range(1, 15));
   endfunction

   task automatic send_sample(input logic start, input logic [ROW_WIDTH-1:0] row,
                              input logic [LINE_WIDTH-1:0] cols);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_start_req     <= start;
      req_row_select    <= row;
      req_column_sample <= cols;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_scan_results.push_back(next_scan_result(start, row, cols));
      requests_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_scan_results.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      store_setting(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic write_settings(input logic [CONFIRM_WIDTH-1:0] confirm,
                                 input logic [COUNT_WIDTH-1:0] quiet,
                                 input logic [COUNT_WIDTH-1:0] hold);
      wait_drained();
      write_register(CSR_CONFIRM_READS, {8'($urandom_range(255)), confirm});
      write_register(CSR_QUIET_READS, quiet);
      write_register(CSR_HOLD_LIMIT, hold);
   endtask

   function automatic void compare_field(string name, logic [CODE_WIDTH-1:0] want,
                                         logic [CODE_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : response_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_scan_results.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_scan_results.pop_front();
            compare_field("row_drive", 5'(want.row_drive), 5'(rsp_row_drive));
            compare_field("done_res", 5'(want.done_res), 5'(rsp_done_res));
            compare_field("checked_row", 5'(want.checked_row), 5'(rsp_checked_row));
            compare_field("key_code", want.key_code, rsp_key_code);
            compare_field("busy_res", 5'(want.busy_res), 5'(rsp_busy_res));
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("keypad_row_scan_debounce_unit test failed");
      $finish;
   end

   // no key, two or more keys (also non-adjacent), idle sample without start
   task automatic test_immediate_codes();
      send_sample(1'b1, 2'd0, 4'b0000);
      send_sample(1'b1, 2'd3, 4'b1111);
      send_sample(1'b1, 2'd2, 4'b0101);
      send_sample(1'b0, 2'd1, 4'b1111);
   endtask

   // single key, one confirm sample, then a released sample aborts
   task automatic test_confirm_abort();
      send_sample(1'b1, 2'd1, 4'b0001);
      send_sample(1'b0, 2'd0, 4'b0001);
      send_sample(1'b0, 2'd2, 4'b0000);
   endtask

   // zero registers act as one; start while busy is ignored
   task automatic test_zero_registers();
      write_settings(8'd0, 16'd0, 16'd0);
      send_sample(1'b1, 2'd2, 4'b1000);
      send_sample(1'b1, 2'd0, 4'b0100);
      send_sample(1'b1, 2'd3, 4'b0000);
      send_sample(1'b1, 2'd3, 4'b0010);
      send_sample(1'b0, 2'd0, 4'b1111);
      send_sample(1'b0, 2'd0, 4'b1111);
   endtask

   // unused index ignored, upper data bits of confirm_reads dropped, quiet end
   task automatic test_register_masking();
      wait_drained();
      write_register(CSR_UNUSED_INDEX, 16'($urandom_range(65535)));
      write_register(CSR_CONFIRM_READS, {8'($urandom_range(1, 255)), 8'd2});
      write_register(CSR_QUIET_READS, 16'd2);
      write_register(CSR_HOLD_LIMIT, 16'd65535);
      send_sample(1'b1, 2'd1, 4'b0100);
      send_sample(1'b0, 2'd0, 4'b0001);
      send_sample(1'b0, 2'd0, 4'b0001);
      send_sample(1'b0, 2'd0, 4'b0000);
      send_sample(1'b0, 2'd0, 4'b0000);
   endtask

   // register change mid-check, hold limit end, row lines keep last pattern
   task automatic test_write_during_check();
      write_settings(8'd3, 16'd5, 16'd3);
      send_sample(1'b1, 2'd3, 4'b0010);
      send_sample(1'b0, 2'd0, 4'b0010);
      wait_drained();
      write_register(CSR_CONFIRM_READS, 16'd1);
      send_sample(1'b0, 2'd0, 4'b0011);
      send_sample(1'b0, 2'd1, 4'b0100);
      send_sample(1'b0, 2'd1, 4'b0100);
      send_sample(1'b0, 2'd1, 4'b0100);
      send_sample(1'b0, 2'd2, 4'b0000);
   endtask

   task automatic test_random_phase(input int n, input int idle, input int stall,
                                    input logic [CONFIRM_WIDTH-1:0] confirm,
                                    input logic [COUNT_WIDTH-1:0] quiet,
                                    input logic [COUNT_WIDTH-1:0] hold);
      int target;
      int r;
      int n_confirm;
      int abort_at;
      int rel_len;
      int press_pct;
      logic [LINE_WIDTH-1:0] first;
      write_settings(confirm, quiet, hold);
      idle_pct  = idle;
      stall_pct = stall;
      target = requests_sent + n;
      while (requests_sent < target) begin
         r = int'($urandom_range(99));
         if (r < 15) begin
            send_sample(1'($urandom_range(1)), 2'($urandom_range(3)),
                        4'($urandom_range(15)));
         end else begin
            first = (r < 23) ? 4'($urandom_range(15)) : one_hot_column();
            send_sample(1'b1, 2'($urandom_range(3)), first);
            n_confirm = int'(scan_cfg.confirm_reads) + int'($urandom_range(2)) - 1;
            abort_at = ($urandom_range(9) == 0) ? int'($urandom_range(7)) : -1;
            for (int i = 0; i < n_confirm; i++)
               send_sample(1'($urandom_range(1)), 2'($urandom_range(3)),
                           (i == abort_at) ? 4'd0 : pressed_columns());
            rel_len = int'($urandom_range(1, int'(scan_cfg.hold_limit) + 2));
            press_pct = int'($urandom_range(60));
            for (int i = 0; i < rel_len; i++)
               send_sample(1'($urandom_range(1)), 2'($urandom_range(3)),
                           (int'($urandom_range(99)) < press_pct) ? pressed_columns() : 4'd0);
         end
      end
   endtask

   // largest confirm count and hold limit, release ended by quiet samples
   task automatic test_extreme_registers();
      write_settings(8'd255, 16'd4, 16'd65535);
      idle_pct  = 0;
      stall_pct = 0;
      send_sample(1'b1, 2'd1, 4'b1000);
      for (int i = 0; i < 255; i++)
         send_sample(1'($urandom_range(1)), 2'($urandom_range(3)), pressed_columns());
      for (int i = 0; i < 6; i++)
         send_sample(1'($urandom_range(1)), 2'($urandom_range(3)), pressed_columns());
      for (int i = 0; i < 4; i++)
         send_sample(1'($urandom_range(1)), 2'($urandom_range(3)), 4'd0);
      send_sample(1'b0, 2'd0, 4'b0000);
   endtask

   initial begin
      reset_scan_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_immediate_codes();
      test_confirm_abort();
      test_zero_registers();
      test_register_masking();
      test_write_during_check();
      test_random_phase(330, 0, 0, 8'd1, 16'd1, 16'd1);
      test_random_phase(330, 83, 0, 8'($urandom_range(1, 4)),
                        16'($urandom_range(1, 8)), 16'($urandom_range(1, 20)));
      test_random_phase(330, 0, 83, 8'($urandom_range(1, 4)),
                        16'($urandom_range(1, 8)), 16'($urandom_range(1, 20)));
      test_random_phase(330, 11, 11, 8'($urandom_range(1, 4)),
                        16'($urandom_range(1, 8)), 16'($urandom_range(1, 20)));
      test_extreme_registers();

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("keypad_row_scan_debounce_unit test passed");
      else
         $display("keypad_row_scan_debounce_unit test failed");
      $finish;
   end

endmodule

FILE: files.f
hdl/krsd_pkg.sv
hdl/krsd_scan_fsm.sv
hdl/keypad_row_scan_debounce_unit.sv
tb/tb.sv
